/* hw/rtl/hhp_pkg.sv */
// Shared types and constants for the hashed history hit predictor.
`default_nettype none

package hhp_pkg;

    localparam int HISTORY_LEN_DEF = 4;
    localparam int HASH_BITS_DEF   = 9;

    localparam int LINE_SHIFT = 6;
    localparam int FOLD_SHIFT = 29;
    localparam int NUM_LEVELS = 3;

    localparam int HIST_W = 4;
    localparam int POS_W  = 2;
    localparam int THR_W  = 3;
    localparam int CNT_W  = 3;

    localparam logic [THR_W-1:0] THRESH_RESET  = 3'd2;
    localparam logic [CNT_W-1:0] FORCED_BUCKET = 3'd4;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam logic [1:0] LEVEL_L1     = 2'd0;
    localparam logic [1:0] LEVEL_L2     = 2'd1;
    localparam logic [1:0] LEVEL_L3     = 2'd2;
    localparam logic [1:0] LEVEL_UNUSED = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [1:0]  level;
        logic        is_write;
        logic [63:0] address;
        logic        outcome;
    } in_item_t;

    typedef struct packed {
        logic             prediction;
        logic [CNT_W-1:0] confidence_bucket;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [HIST_W-1:0] hist;
    } entry_t;

    // Evaluation result handed from the datapath to the control.
    typedef struct packed {
        out_item_t result;
        logic      do_write;
        entry_t    wr_entry;
    } eval_t;

endpackage

`default_nettype wire

/* hw/rtl/hhp_table.sv */
// History table: single write port, one registered read port.
`default_nettype none

module hhp_table
    import hhp_pkg::*;
#(
    parameter int DEPTH = NUM_LEVELS * (1 << HASH_BITS_DEF),
    parameter int AW    = HASH_BITS_DEF + 2
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/hhp_eval.sv */
// Row evaluation: popcount, threshold compare and history/position update.
`default_nettype none

module hhp_eval
    import hhp_pkg::*;
#(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF
)
(
    input  wire in_item_t         item,
    input  wire entry_t           rd_entry,
    input  wire logic [THR_W-1:0] threshold,
    output eval_t                 ev
);

    localparam logic [POS_W:0] HL = (POS_W + 1)'(HISTORY_LEN);

    logic             valid_level;
    logic             forced;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W:0]   pos_inc;
    logic [HIST_W-1:0] hist_next;

    always_comb
    begin
        valid_level = (item.level != LEVEL_UNUSED);
        forced      = valid_level && (item.level != LEVEL_L1) && item.is_write;

        count = '0;
        for (int i = 0; i < HIST_W; i++)
        begin
            if (i < HISTORY_LEN)
            begin
                count = count + CNT_W'(rd_entry.hist[i]);
            end
        end
        if (!valid_level)
        begin
            count = '0;
        end

        // stale positions at or past the history length wrap to zero
        pos_eff = ({1'b0, rd_entry.pos} >= HL) ? '0 : rd_entry.pos;
        pos_inc = {1'b0, pos_eff} + (POS_W + 1)'(1);

        hist_next          = rd_entry.hist;
        hist_next[pos_eff] = item.outcome;

        ev.wr_entry.hist = hist_next;
        ev.wr_entry.pos  = (pos_inc >= HL) ? '0 : pos_inc[POS_W-1:0];
        ev.do_write      = (item.kind == KIND_UPDATE) && valid_level && !forced;

        if (forced)
        begin
            ev.result.prediction        = 1'b1;
            ev.result.confidence_bucket = FORCED_BUCKET;
        end
        else
        begin
            ev.result.prediction        = (count >= threshold);
            ev.result.confidence_bucket = count;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hashed_history_hit_predictor_core.sv */
// Top level of the hashed history hit predictor: control, table and output stage.
// Flow: an accepted beat's item and table row are registered, it is evaluated in the execute
// state, and a predict result is registered into the output stage. A new beat is taken only
//   after the last one leaves the execute state; a stalled output holds the next predict result.
// Reset: threshold returns to 2; a clearing pass then zeroes all 3 * 2^HASH_BITS rows
//   (1536 at defaults), one row a cycle, with in_stall high; config is always taken.
`default_nettype none

module hashed_history_hit_predictor_core
    import hhp_pkg::*;
#(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int HASH_BITS   = HASH_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [THR_W-1:0] cfg_data
);

    // Rows per level are a power of two, so level*rows + row is {level, row}.
    localparam int DEPTH = NUM_LEVELS * (1 << HASH_BITS);
    localparam int AW    = HASH_BITS + 2;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    in_item_t         item_reg;
    logic [THR_W-1:0] thr_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;

    logic             in_fire;
    logic             out_free;
    logic             load_out;
    logic [1:0]       rd_level;
    logic [HASH_BITS-1:0] rd_row;
    logic [AW-1:0]    rd_idx;
    logic [AW-1:0]    item_idx;
    logic [HASH_BITS-1:0] item_row;
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    entry_t           tbl_wdata;
    entry_t           tbl_rdata;
    eval_t            ev;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // Row hash: line address bits folded, low HASH_BITS kept.
    // Unused level 3 has no table; its read goes to the hashed row of level 1 and is ignored.
    assign rd_level = (in_data.level == LEVEL_UNUSED) ? LEVEL_L1 : in_data.level;
    assign rd_row   = in_data.address[LINE_SHIFT +: HASH_BITS]
                    ^ in_data.address[LINE_SHIFT + FOLD_SHIFT +: HASH_BITS];
    assign rd_idx   = {rd_level, rd_row};

    assign item_row = item_reg.address[LINE_SHIFT +: HASH_BITS]
                    ^ item_reg.address[LINE_SHIFT + FOLD_SHIFT +: HASH_BITS];
    assign item_idx = {item_reg.level, item_row};

    // ---------------------------------------------------------------
    // Table and evaluation
    // ---------------------------------------------------------------
    hhp_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (in_fire),
        .raddr (rd_idx),
        .rdata (tbl_rdata)
    );

    hhp_eval #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_eval (
        .item      (item_reg),
        .rd_entry  (tbl_rdata),
        .threshold (thr_reg),
        .ev        (ev)
    );

    // Write mux: clearing sweep, or write-back in the execute cycle.
    // Only one beat is in flight, so the next read always sees this write.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = '0;
        end
        else
        begin
            tbl_we    = (state_reg == ST_EXEC) && ev.do_write;
            tbl_waddr = item_idx;
            tbl_wdata = ev.wr_entry;
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    assign load_out = (state_reg == ST_EXEC) && (item_reg.kind == KIND_PREDICT) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // a predict beat waits here while the output stage is full
                if ((item_reg.kind == KIND_UPDATE) || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            thr_reg       <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (load_out)
        begin
            out_data_reg <= ev.result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // an accepted beat is always evaluated in the following cycle
    a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted beat not evaluated next cycle");

    // outside the sweep, only update beats at a used level write the table
    a_no_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && tbl_we) |->
            (item_reg.level != LEVEL_UNUSED) && (item_reg.kind == KIND_UPDATE))
        else $error("table written for an ignored beat");

    // update beats produce no result beat
    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && item_reg.kind == KIND_UPDATE && !out_valid_reg)
            |=> !out_valid_reg)
        else $error("update beat produced a result");
`endif

endmodule

`default_nettype wire
